// ===== design/twre_pkg.sv =====
// ----------------------------------------------------------------------------
// twre_pkg - shared definitions for the two-window ramp envelope
// widths, fixed-point constants, register map and pipeline payload types
// ----------------------------------------------------------------------------
`default_nettype none

package twre_pkg;

    // time and fraction widths
    localparam int TIME_BITS   = 32;
    localparam int FRAC_BITS   = 16;
    localparam int WORK_FRAC   = 30;
    localparam int WORK_W      = WORK_FRAC + 1;
    localparam int R_SHIFT     = WORK_FRAC - FRAC_BITS;
    localparam int PROD_W      = 2 * WORK_W;
    localparam int LEVEL_W     = 16;
    localparam int LEVEL_SHIFT = WORK_W - LEVEL_W;

    // configuration port
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;

    // Q1.30 constants
    localparam logic [WORK_W-1:0] WORK_ONE  = {1'b1, {WORK_FRAC{1'b0}}};
    localparam logic [WORK_W-1:0] WORK_HALF = WORK_ONE >> 1;
    localparam logic [WORK_W-1:0] EASE_B    = 31'd230426967;
    localparam logic [WORK_W-1:0] EASE_A    = EASE_B + WORK_ONE;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {1'b1, {LEVEL_SHIFT{1'b0}}};

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ENABLED       = 3'd0,
        REG_FIRST_START   = 3'd1,
        REG_SECOND_START  = 3'd2,
        REG_RAMP_DURATION = 3'd3,
        REG_SLOPE_RISING  = 3'd4,
        REG_CURVE_COSINE  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic                 enabled;
        logic [TIME_BITS-1:0] first_start;
        logic [TIME_BITS-1:0] second_start;
        logic [TIME_BITS-1:0] ramp_duration;
        logic                 slope_rising;
        logic                 curve_cosine;
    } cfg_t;

    // window decode and divider stages
    typedef struct packed {
        logic                 is_ramp;
        logic                 lin_inv;
        logic                 cosine;
        logic [WORK_W-1:0]    const_val;
        logic [TIME_BITS-1:0] rem;
        logic [TIME_BITS-1:0] den;
        logic [FRAC_BITS-1:0] q;
    } div_t;

    // easing stages
    typedef struct packed {
        logic              is_ramp;
        logic              lin_inv;
        logic              cosine;
        logic              low;
        logic [WORK_W-1:0] const_val;
        logic [WORK_W-1:0] r;
        logic [WORK_W-1:0] p;
        logic [WORK_W-1:0] pb;
        logic [WORK_W-1:0] poly;
    } ease_t;

endpackage

`default_nettype wire

// ===== design/twre_if.sv =====
// ----------------------------------------------------------------------------
// twre_if - item channels of the two-window ramp envelope
// valid/ready channels for timestamp queries and level results
// ----------------------------------------------------------------------------
`default_nettype none

interface twre_time_if;
    logic                           valid;
    logic                           ready;
    logic [twre_pkg::TIME_BITS-1:0] now_time;

    modport source (output valid, output now_time, input ready);
    modport sink   (input valid, input now_time, output ready);
endinterface

interface twre_level_if;
    logic                         valid;
    logic                         ready;
    logic [twre_pkg::LEVEL_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

`default_nettype wire

// ===== design/twre_cfg.sv =====
// ----------------------------------------------------------------------------
// twre_cfg - configuration registers
// apb-style register file holding the window and curve settings
// ----------------------------------------------------------------------------
`default_nettype none

module twre_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [twre_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [twre_pkg::DATA_W-1:0]   pwdata,
    output logic      [twre_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output twre_pkg::cfg_t                     cfg
);

    twre_pkg::cfg_t     cfg_reg;
    twre_pkg::cfg_t     cfg_next;
    twre_pkg::reg_idx_t idx;
    logic               wr;

    assign pready = 1'b1;
    assign idx    = twre_pkg::reg_idx_t'(paddr[twre_pkg::ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                twre_pkg::REG_ENABLED:       cfg_next.enabled = pwdata[0];
                twre_pkg::REG_FIRST_START:
                    cfg_next.first_start = pwdata[twre_pkg::TIME_BITS-1:0];
                twre_pkg::REG_SECOND_START:
                    cfg_next.second_start = pwdata[twre_pkg::TIME_BITS-1:0];
                twre_pkg::REG_RAMP_DURATION:
                    cfg_next.ramp_duration = pwdata[twre_pkg::TIME_BITS-1:0];
                twre_pkg::REG_SLOPE_RISING:  cfg_next.slope_rising = pwdata[0];
                twre_pkg::REG_CURVE_COSINE:  cfg_next.curve_cosine = pwdata[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled       <= 1'b0;
            cfg_reg.first_start   <= '0;
            cfg_reg.second_start  <= '0;
            cfg_reg.ramp_duration <= '0;
            cfg_reg.slope_rising  <= 1'b1;
            cfg_reg.curve_cosine  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        case (idx)
            twre_pkg::REG_ENABLED:
                prdata = {{(twre_pkg::DATA_W-1){1'b0}}, cfg_reg.enabled};
            twre_pkg::REG_FIRST_START:   prdata = cfg_reg.first_start;
            twre_pkg::REG_SECOND_START:  prdata = cfg_reg.second_start;
            twre_pkg::REG_RAMP_DURATION: prdata = cfg_reg.ramp_duration;
            twre_pkg::REG_SLOPE_RISING:
                prdata = {{(twre_pkg::DATA_W-1){1'b0}}, cfg_reg.slope_rising};
            twre_pkg::REG_CURVE_COSINE:
                prdata = {{(twre_pkg::DATA_W-1){1'b0}}, cfg_reg.curve_cosine};
            default:                     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/twre_window.sv =====
// ----------------------------------------------------------------------------
// twre_window - window decode stage
// classifies a timestamp against both windows, sets up the division
// ----------------------------------------------------------------------------
`default_nettype none

module twre_window (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire twre_pkg::cfg_t cfg,
    twre_time_if.sink           in_ch,
    output logic                out_valid,
    input  wire logic           out_ready,
    output twre_pkg::div_t      out_data
);

    logic                             valid_reg;
    twre_pkg::div_t                   data_reg;
    twre_pkg::div_t                   data_next;
    logic                             rdy;
    logic [twre_pkg::TIME_BITS-1:0]   now;
    logic [twre_pkg::TIME_BITS:0]     now_x;
    logic [twre_pkg::TIME_BITS:0]     end1;
    logic [twre_pkg::TIME_BITS:0]     end2;
    logic                             rise;

    assign rdy         = !valid_reg || out_ready;
    assign in_ch.ready = rdy;
    assign out_valid   = valid_reg;
    assign out_data    = data_reg;

    assign now   = in_ch.now_time;
    assign now_x = {1'b0, now};
    assign end1  = {1'b0, cfg.first_start} + {1'b0, cfg.ramp_duration};
    assign end2  = {1'b0, cfg.second_start} + {1'b0, cfg.ramp_duration};
    assign rise  = cfg.slope_rising;

    always_comb
    begin
        data_next           = '0;
        data_next.cosine    = cfg.curve_cosine;
        data_next.den       = cfg.ramp_duration;
        if (!cfg.enabled || cfg.first_start == '0)
        begin
            data_next.const_val = '0;
        end
        else if (now > cfg.first_start && now_x < end1)
        begin
            // inside the first window
            data_next.is_ramp = 1'b1;
            data_next.rem     = now - cfg.first_start;
            data_next.lin_inv = !rise;
        end
        else if (cfg.second_start == '0)
        begin
            if (now <= cfg.first_start)
                data_next.const_val = rise ? '0 : twre_pkg::WORK_ONE;
            else
                data_next.const_val = rise ? twre_pkg::WORK_ONE : '0;
        end
        else if (now <= cfg.second_start)
        begin
            data_next.const_val = rise ? twre_pkg::WORK_ONE : '0;
        end
        else if (now_x >= end2)
        begin
            data_next.const_val = rise ? '0 : twre_pkg::WORK_ONE;
        end
        else
        begin
            // inside the return window
            data_next.is_ramp = 1'b1;
            data_next.rem     = now - cfg.second_start;
            data_next.lin_inv = rise;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (rdy)
            valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy && in_ch.valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== design/twre_div.sv =====
// ----------------------------------------------------------------------------
// twre_div - pipelined restoring divider
// one quotient bit per stage, forms the q0.16 window ratio
// ----------------------------------------------------------------------------
`default_nettype none

module twre_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire twre_pkg::div_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output twre_pkg::div_t      out_data
);

    localparam int N = twre_pkg::FRAC_BITS;

    twre_pkg::div_t data_reg  [N];
    twre_pkg::div_t stage_in  [N];
    twre_pkg::div_t stage_out [N];
    logic [N-1:0]   valid_reg;
    logic [N-1:0]   stage_vin;
    logic [N:0]     rdy;

    assign rdy[N]    = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[N-1];
    assign out_data  = data_reg[N-1];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [twre_pkg::TIME_BITS:0] rem2;
        logic [twre_pkg::TIME_BITS:0] diff;

        if (i == 0)
        begin : g_first
            assign stage_in[i]  = in_data;
            assign stage_vin[i] = in_valid;
        end
        else
        begin : g_rest
            assign stage_in[i]  = data_reg[i-1];
            assign stage_vin[i] = valid_reg[i-1];
        end

        assign rdy[i] = !valid_reg[i] || rdy[i+1];
        assign rem2   = {stage_in[i].rem, 1'b0};
        assign diff   = rem2 - {1'b0, stage_in[i].den};

        always_comb
        begin
            stage_out[i]   = stage_in[i];
            stage_out[i].q = {stage_in[i].q[N-2:0], 1'b0};
            if (rem2 >= {1'b0, stage_in[i].den})
            begin
                stage_out[i].rem  = diff[twre_pkg::TIME_BITS-1:0];
                stage_out[i].q[0] = 1'b1;
            end
            else
            begin
                stage_out[i].rem = rem2[twre_pkg::TIME_BITS-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (rdy[i])
                valid_reg[i] <= stage_vin[i];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i] && stage_vin[i])
                data_reg[i] <= stage_out[i];
        end
    end

endmodule

`default_nettype wire

// ===== design/twre_ease.sv =====
// ----------------------------------------------------------------------------
// twre_ease - easing curve and output stages
// quartic cosine-like easing over three multiply stages, level output register
// ----------------------------------------------------------------------------
`default_nettype none

module twre_ease (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire twre_pkg::div_t in_data,
    twre_level_if.source        out_ch
);

    localparam int WW = twre_pkg::WORK_W;
    localparam int PW = twre_pkg::PROD_W;
    localparam int HI = twre_pkg::WORK_FRAC + WW - 1;
    localparam int LO = twre_pkg::WORK_FRAC;

    twre_pkg::ease_t e0_reg, e1_reg, e2_reg;
    twre_pkg::ease_t e0_next, e1_next, e2_next;
    logic [twre_pkg::LEVEL_W-1:0] level_reg;
    logic [twre_pkg::LEVEL_W-1:0] level_next;
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic rdy0, rdy1, rdy2, rdy3;

    logic [WW-1:0] r;
    logic [WW:0]   z2;
    logic [WW:0]   w_wide;
    logic [WW-1:0] w;
    logic          low;
    logic [PW-1:0] w_x, p1_x, b_x, p2_x, t_x;
    logic [PW-1:0] prod_w, prod_b, prod_t;
    logic [WW-1:0] t;
    logic [WW-1:0] poly_raw;
    logic [WW-1:0] half;
    logic [WW-1:0] c;
    logic [WW-1:0] v;

    assign rdy3 = !v3_reg || out_ch.ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;
    assign in_ready     = rdy0;
    assign out_ch.valid = v3_reg;
    assign out_ch.level = level_reg;

    // stage 0: ratio to q1.30, fold about one half, square
    assign r   = {1'b0, in_data.q, {twre_pkg::R_SHIFT{1'b0}}};
    assign z2  = {r, 1'b0};
    assign low = r <= twre_pkg::WORK_HALF;
    assign w_wide = low ? z2 : ({1'b1, {WW{1'b0}}} - z2);
    assign w   = (w_wide > {1'b0, twre_pkg::WORK_ONE}) ? twre_pkg::WORK_ONE
                                                       : w_wide[WW-1:0];
    assign w_x    = {{(PW-WW){1'b0}}, w};
    assign prod_w = w_x * w_x;

    always_comb
    begin
        e0_next           = '0;
        e0_next.is_ramp   = in_data.is_ramp;
        e0_next.lin_inv   = in_data.lin_inv;
        e0_next.cosine    = in_data.cosine;
        e0_next.const_val = in_data.const_val;
        e0_next.low       = low;
        e0_next.r         = r;
        e0_next.p         = prod_w[HI:LO];
    end

    // stage 1: p * b
    assign p1_x   = {{(PW-WW){1'b0}}, e0_reg.p};
    assign b_x    = {{(PW-WW){1'b0}}, twre_pkg::EASE_B};
    assign prod_b = p1_x * b_x;

    always_comb
    begin
        e1_next    = e0_reg;
        e1_next.pb = prod_b[HI:LO];
    end

    // stage 2: p * (a - p * b), limited to one
    assign t        = twre_pkg::EASE_A - e1_reg.pb;
    assign p2_x     = {{(PW-WW){1'b0}}, e1_reg.p};
    assign t_x      = {{(PW-WW){1'b0}}, t};
    assign prod_t   = p2_x * t_x;
    assign poly_raw = prod_t[HI:LO];

    always_comb
    begin
        e2_next      = e1_reg;
        e2_next.poly = (poly_raw > twre_pkg::WORK_ONE) ? twre_pkg::WORK_ONE : poly_raw;
    end

    // stage 3: pick constant, linear or eased value, drop to q1.15
    assign half = e2_reg.poly >> 1;
    assign c    = e2_reg.low ? (twre_pkg::WORK_ONE - half) : half;

    always_comb
    begin
        if (!e2_reg.is_ramp)
            v = e2_reg.const_val;
        else if (!e2_reg.cosine)
            v = e2_reg.lin_inv ? (twre_pkg::WORK_ONE - e2_reg.r) : e2_reg.r;
        else
            v = e2_reg.lin_inv ? c : (twre_pkg::WORK_ONE - c);
        level_next = v[WW-1 -: twre_pkg::LEVEL_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= in_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
            e0_reg <= e0_next;
        if (rdy1 && v0_reg)
            e1_reg <= e1_next;
        if (rdy2 && v1_reg)
            e2_reg <= e2_next;
        if (rdy3 && v2_reg)
            level_reg <= level_next;
    end

endmodule

`default_nettype wire

// ===== design/two_window_ramp_envelope_top.sv =====
// ----------------------------------------------------------------------------
// two_window_ramp_envelope_top - two-window ramp envelope
// maps millisecond timestamps to a q1.15 animation level
// ----------------------------------------------------------------------------
// Each item on the query channel is a 32-bit millisecond timestamp and gives
// exactly one level item (unsigned q1.15, 32768 = 1.0) on the result channel,
// in order. The block holds no state between items: a new query is taken
// every clock cycle while results drain, and each one passes 21 register
// stages (1 window decode stage, 16 divider stages at one quotient bit each,
// 3 easing stages, 1 output stage). Throughput is one item per cycle while
// results drain. A stage waits only when it is full and its successor cannot
// move, so bubbles close up and queries keep flowing into empty stages while
// a result waits. Settings are written over the apb-style port (byte address
// 4*index) while no item is in flight; the user must ensure it, the block
// does not enforce it. No clearing pass runs after reset.
`default_nettype none

module two_window_ramp_envelope_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [twre_pkg::ADDR_W-1:0] paddr,
    input  wire logic [twre_pkg::DATA_W-1:0] pwdata,
    output logic      [twre_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    twre_time_if.sink                        query,
    twre_level_if.source                     result
);

    twre_pkg::cfg_t cfg;

    // window decode -> divider
    logic           win_valid;
    logic           win_ready;
    twre_pkg::div_t win_data;

    // divider -> easing
    logic           div_valid;
    logic           div_ready;
    twre_pkg::div_t div_data;

    // register file; the user keeps settings static while items are in flight
    twre_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // compare against both windows, pick a held level or a ramp numerator
    twre_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_ch     (query),
        .out_valid (win_valid),
        .out_ready (win_ready),
        .out_data  (win_data)
    );

    // ratio (now - start) / duration, one bit per stage
    twre_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .in_data   (win_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    // linear or eased curve, slope direction, output register
    twre_ease u_ease (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .in_ready (div_ready),
        .in_data  (div_data),
        .out_ch   (result)
    );

    // a level never goes above 1.0
    a_level_bound : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.level <= twre_pkg::LEVEL_MAX))
        else $error("level item above 1.0");

    // with the output register free, every stage can move, so a query is taken
    a_query_flow : assert property (@(posedge clk) disable iff (!rst_n)
        (!result.valid || result.ready) |-> query.ready)
        else $error("query stalled while output side can drain");

endmodule

`default_nettype wire
